>>> sv/mpfb_pkg.sv
// shared types and codes for the page-ordered frame store
package mpfb_pkg;

	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_FILL  = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	localparam logic [1:0] PEN_SET   = 2'd0;
	localparam logic [1:0] PEN_ERASE = 2'd1;
	localparam logic [1:0] PEN_INV   = 2'd2;

	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] x_a;
		logic [7:0] y_a;
		logic [7:0] x_b;
		logic [7:0] y_b;
		logic [1:0] pen;
	} in_t;

	typedef struct packed {
		logic [7:0] column_byte;
		logic       read_valid;
	} res_t;

	typedef enum logic [1:0] {
		K_WALK,
		K_FILL,
		K_READ,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] pen;
		logic [7:0] x0;
		logic [7:0] y0;
		logic [7:0] cnt;
		logic       col_step;
		logic       dec;
		logic [7:0] dx_abs;
		logic [7:0] dy_abs;
		logic       dy_neg;
		logic       rd_ok;
	} cmd_t;

endpackage

>>> sv/mpfb_front.sv
// command classifier: turns an input item into a walk, fill, read or no-op
module mpfb_front import mpfb_pkg::*; #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGES        = 8
) (
	input  in_t  item,
	output cmd_t cmd
);

	logic [7:0] dx_abs;
	logic [7:0] dy_abs;
	logic       x_rev;
	logic       y_rev;

	always_comb begin
		x_rev  = item.x_b < item.x_a;
		y_rev  = item.y_b < item.y_a;
		dx_abs = x_rev ? item.x_a - item.x_b : item.x_b - item.x_a;
		dy_abs = y_rev ? item.y_a - item.y_b : item.y_b - item.y_a;

		cmd          = '0;
		cmd.kind     = K_NOP;
		cmd.pen      = item.pen;
		cmd.x0       = item.x_a;
		cmd.y0       = item.y_a;
		cmd.col_step = 1'b1;
		cmd.rd_ok    = ({1'b0, item.x_a} < 9'(SCREEN_WIDTH)) &&
			({1'b0, item.y_a} < 9'(PAGES));

		unique case (item.mode)
			MODE_PIXEL: begin
				// a single point is a walk with no steps
				cmd.kind = K_WALK;
			end
			MODE_LINE: begin
				cmd.kind = K_WALK;
				if (item.x_a == item.x_b && item.y_a != item.y_b) begin
					// vertical run from the lower row up
					cmd.col_step = 1'b0;
					cmd.y0       = y_rev ? item.y_b : item.y_a;
					cmd.cnt      = dy_abs;
				end else begin
					cmd.cnt    = dx_abs;
					cmd.dec    = x_rev;
					cmd.dx_abs = dx_abs;
					cmd.dy_abs = dy_abs;
					cmd.dy_neg = y_rev;
				end
			end
			MODE_FILL: begin
				if (item.pen == PEN_SET || item.pen == PEN_ERASE) begin
					cmd.kind = K_FILL;
				end
			end
			MODE_READ: begin
				cmd.kind = K_READ;
			end
			default: begin
				cmd.kind = K_NOP;
			end
		endcase
	end

endmodule

>>> sv/mpfb_cmdq.sv
// two-entry command queue between classifier and executor
module mpfb_cmdq import mpfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd,
	output cmd_t rd_cmd,
	output logic q_empty
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rd_cmd  = slot_q[rd_ptr_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> !q_empty)
		else $error("pushed item lost");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

>>> sv/mpfb_back.sv
// command executor: frame store, pixel walker, step divider and result register
module mpfb_back import mpfb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int PAGES         = 8,
	parameter int DEPTH         = 1024,
	parameter int AW            = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_take,
	output res_t res,
	output logic empty,
	input  logic pop,
	output logic clearing
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_PIX,
		S_WR,
		S_FILL,
		S_RDB,
		S_RDW,
		S_DONE
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [7:0]      col_q;
	logic [7:0]      row_q;
	logic [7:0]      cnt_q;
	logic [7:0]      r_q;
	logic [7:0]      rs_q;
	logic signed [9:0] qs_q;
	logic [7:0]      d_q;
	logic [7:0]      div_rem_q;
	logic [7:0]      div_quo_q;
	logic [2:0]      div_cnt_q;
	logic [AW-1:0]   fill_q;
	logic [AW-1:0]   addr_q;
	logic [2:0]      bit_q;
	res_t            pend_q;
	res_t            out_q;
	logic            out_valid_q;

	logic [7:0]      mem_q [DEPTH];
	logic [7:0]      rdata_q;

	logic            re_c;
	logic [AW-1:0]   raddr_c;
	logic            we_c;
	logic [AW-1:0]   waddr_c;
	logic [7:0]      wdata_c;

	logic            on_screen;
	logic [AW-1:0]   pix_addr;
	logic [AW-1:0]   rd_addr;
	logic [8:0]      rsum;
	logic            carry;
	logic [7:0]      r_next;
	logic [7:0]      row_next;
	logic [8:0]      div_sh;
	logic            div_ge;
	logic [7:0]      mask;
	logic [7:0]      pix_byte;
	logic            slot_free;

	assign res       = out_q;
	assign empty     = !out_valid_q;
	assign clearing  = state_q == S_CLEAR;
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid;
	assign slot_free = !out_valid_q || pop;

	always_comb begin
		on_screen = ({1'b0, col_q} < 9'(SCREEN_WIDTH)) &&
			({1'b0, row_q} < 9'(SCREEN_HEIGHT));
		pix_addr = AW'(32'(col_q) * PAGES + 32'(row_q[7:3]));
		rd_addr  = AW'(32'(cmd_q.x0) * PAGES + 32'(cmd_q.y0));

		// remainder walk: r + rs wraps past the column span
		rsum     = {1'b0, r_q} + {1'b0, rs_q};
		carry    = rsum >= {1'b0, d_q};
		r_next   = carry ? 8'(rsum - {1'b0, d_q}) : rsum[7:0];
		row_next = 8'($signed({2'b00, row_q}) + qs_q + $signed({9'd0, carry}));

		div_sh = {div_rem_q, div_quo_q[7]};
		div_ge = div_sh >= {1'b0, d_q};

		mask = 8'd1 << bit_q;
		case (cmd_q.pen)
			PEN_SET: pix_byte = rdata_q | mask;
			PEN_INV: pix_byte = rdata_q ^ mask;
			default: pix_byte = rdata_q & ~mask;
		endcase

		re_c    = 1'b0;
		raddr_c = pix_addr;
		we_c    = 1'b0;
		waddr_c = addr_q;
		wdata_c = pix_byte;
		unique case (state_q)
			S_PIX: begin
				re_c = on_screen;
			end
			S_RDB: begin
				re_c    = 1'b1;
				raddr_c = rd_addr;
			end
			S_WR: begin
				we_c = 1'b1;
			end
			S_CLEAR, S_FILL: begin
				we_c    = 1'b1;
				waddr_c = fill_q;
				wdata_c = (state_q == S_FILL && cmd_q.pen == PEN_SET) ?
					BYTE_ONES : BYTE_ZEROS;
			end
			default: begin
				re_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem_q[waddr_c] <= wdata_c;
		end
		if (re_c) begin
			rdata_q <= mem_q[raddr_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q  <= cmd;
						col_q  <= cmd.x0;
						row_q  <= cmd.y0;
						cnt_q  <= cmd.cnt;
						r_q    <= 8'd0;
						fill_q <= '0;
						pend_q <= '{column_byte: BYTE_ZEROS, read_valid: cmd.kind == K_READ};
						unique case (cmd.kind)
							K_WALK: begin
								if (!cmd.col_step) begin
									qs_q    <= 10'sd1;
									rs_q    <= 8'd0;
									d_q     <= 8'd1;
									state_q <= S_PIX;
								end else if (cmd.dy_abs == 8'd0) begin
									qs_q    <= 10'sd0;
									rs_q    <= 8'd0;
									d_q     <= cmd.dx_abs;
									state_q <= S_PIX;
								end else begin
									d_q       <= cmd.dx_abs;
									div_rem_q <= 8'd0;
									div_quo_q <= cmd.dy_abs;
									div_cnt_q <= 3'd7;
									state_q   <= S_DIV;
								end
							end
							K_FILL: state_q <= S_FILL;
							K_READ: begin
								state_q <= cmd.rd_ok ? S_RDB : S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_DIV: begin
					// one quotient bit per cycle
					div_rem_q <= div_ge ? 8'(div_sh - {1'b0, d_q}) : div_sh[7:0];
					div_quo_q <= {div_quo_q[6:0], div_ge};
					div_cnt_q <= div_cnt_q - 3'd1;
					if (div_cnt_q == 3'd0) begin
						if (!cmd_q.dy_neg) begin
							qs_q <= $signed({2'b00, div_quo_q[6:0], div_ge});
							rs_q <= div_ge ? 8'(div_sh - {1'b0, d_q}) : div_sh[7:0];
						end else if ((div_ge ? 8'(div_sh - {1'b0, d_q}) : div_sh[7:0])
							== 8'd0) begin
							qs_q <= -$signed({2'b00, div_quo_q[6:0], div_ge});
							rs_q <= 8'd0;
						end else begin
							// floor of a negative step rounds one further down
							qs_q <= -$signed({2'b00, div_quo_q[6:0], div_ge}) - 10'sd1;
							rs_q <= d_q - (div_ge ? 8'(div_sh - {1'b0, d_q}) :
								div_sh[7:0]);
						end
						state_q <= S_PIX;
					end
				end
				S_PIX, S_WR: begin
					if (state_q == S_PIX && on_screen) begin
						addr_q  <= pix_addr;
						bit_q   <= row_q[2:0];
						state_q <= S_WR;
					end else if (cnt_q == 8'd0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 8'd1;
						r_q   <= r_next;
						row_q <= row_next;
						if (cmd_q.col_step) begin
							col_q <= cmd_q.dec ? col_q - 8'd1 : col_q + 8'd1;
						end
						state_q <= S_PIX;
					end
				end
				S_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == AW'(DEPTH - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_RDB: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					pend_q.column_byte <= rdata_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						out_q   <= pend_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wr_after_pix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_PIX)
		else $error("store write without a read before it");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_rem_q < d_q)
		else $error("divider remainder not below divisor");

	a_walk_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX && cmd_q.col_step && d_q != 8'd0) |-> r_q < d_q)
		else $error("walk remainder not below span");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> state_q == S_IDLE && !clearing)
		else $error("command taken while busy");

endmodule

>>> sv/mono_page_framebuffer_draw.sv
// top level: page-ordered monochrome frame store with pixel, line, fill and read
// pixel: one read-modify-write of a store byte
// line: one read-modify-write per on-screen pixel, after a bit-serial step division for a sloped line
// fill: writes every store byte in turn; read: fetches one store byte; a 2-entry queue decouples input
// after reset the store is cleared one byte a cycle over all width*pages bytes, full held high
// every item gives one result, held in an output register until popped
module mono_page_framebuffer_draw import mpfb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  cmd,
	output logic empty,
	input  logic pop,
	output res_t res
);

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = SCREEN_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	cmd_t front_cmd;
	cmd_t q_cmd;
	logic q_full;
	logic q_empty;
	logic q_take;
	logic clearing;

	assign full = q_full || clearing;

	mpfb_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.PAGES       (PAGES)
	) u_front (
		.item(cmd),
		.cmd (front_cmd)
	);

	mpfb_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push && !full),
		.wr_cmd (front_cmd),
		.q_full (q_full),
		.rd     (q_take),
		.rd_cmd (q_cmd),
		.q_empty(q_empty)
	);

	mpfb_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.PAGES        (PAGES),
		.DEPTH        (DEPTH),
		.AW           (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (q_cmd),
		.cmd_valid(!q_empty),
		.cmd_take (q_take),
		.res      (res),
		.empty    (empty),
		.pop      (pop),
		.clearing (clearing)
	);

endmodule
